// File: rtl/core/kwl_pkg.sv
// ----------------------------------------------------------------------------
// kwl_pkg: shared types and codes of the keyword token lexer
// Token kinds, scan modes, character classes and keyword matching.
// ----------------------------------------------------------------------------
package kwl_pkg;

	localparam int COLUMN_BITS_DEF = 12;
	localparam int LINE_BITS_DEF   = 16;
	localparam int KIND_BITS       = 4;
	localparam int PREFIX_LEN      = 5;
	localparam int QUEUE_DEPTH     = 4;

	// token kinds
	localparam logic [KIND_BITS-1:0] TK_PLUS    = 4'd0;
	localparam logic [KIND_BITS-1:0] TK_MINUS   = 4'd1;
	localparam logic [KIND_BITS-1:0] TK_MULT    = 4'd2;
	localparam logic [KIND_BITS-1:0] TK_DIV     = 4'd3;
	localparam logic [KIND_BITS-1:0] TK_EQUAL   = 4'd4;
	localparam logic [KIND_BITS-1:0] TK_SEMI    = 4'd5;
	localparam logic [KIND_BITS-1:0] TK_VAR     = 4'd6;
	localparam logic [KIND_BITS-1:0] TK_IF      = 4'd7;
	localparam logic [KIND_BITS-1:0] TK_THEN    = 4'd8;
	localparam logic [KIND_BITS-1:0] TK_END     = 4'd9;
	localparam logic [KIND_BITS-1:0] TK_PRINT   = 4'd10;
	localparam logic [KIND_BITS-1:0] TK_IDENT   = 4'd11;
	localparam logic [KIND_BITS-1:0] TK_INT     = 4'd12;
	localparam logic [KIND_BITS-1:0] TK_UNKNOWN = 4'd13;

	// scan modes
	localparam logic [2:0] MODE_IDLE    = 3'd0;
	localparam logic [2:0] MODE_SLASH   = 3'd1;
	localparam logic [2:0] MODE_COMMENT = 3'd2;
	localparam logic [2:0] MODE_WORD    = 3'd3;
	localparam logic [2:0] MODE_NUMBER  = 3'd4;

	// item kinds
	localparam logic ITEM_CHAR = 1'b0;
	localparam logic ITEM_EOL  = 1'b1;

	localparam logic [7:0] CH_PLUS  = "+";
	localparam logic [7:0] CH_MINUS = "-";
	localparam logic [7:0] CH_MULT  = "*";
	localparam logic [7:0] CH_EQUAL = "=";
	localparam logic [7:0] CH_SEMI  = ";";
	localparam logic [7:0] CH_SLASH = "/";

	typedef logic [PREFIX_LEN-1:0][7:0] prefix_t;

	// element 0 holds the first character
	localparam prefix_t KW_VAR   = {8'h00, 8'h00, "r", "a", "v"};
	localparam prefix_t KW_IF    = {8'h00, 8'h00, 8'h00, "f", "i"};
	localparam prefix_t KW_THEN  = {8'h00, "n", "e", "h", "t"};
	localparam prefix_t KW_END   = {8'h00, 8'h00, "d", "n", "e"};
	localparam prefix_t KW_PRINT = {"t", "n", "i", "r", "p"};

	typedef struct packed {
		logic       valid;
		logic       kind;
		logic [7:0] char_code;
	} step_t;

	typedef struct packed {
		logic p0;
		logic p1;
	} push_t;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == " " || (c >= 8'd9 && c <= 8'd13);
	endfunction

	// len is only meaningful for runs of at most PREFIX_LEN characters
	function automatic logic [KIND_BITS-1:0] word_kind(input prefix_t p, input logic [2:0] len);
		logic [KIND_BITS-1:0] k;
		k = TK_IDENT;
		if (len == 3'd3 && p == KW_VAR)        k = TK_VAR;
		else if (len == 3'd2 && p == KW_IF)    k = TK_IF;
		else if (len == 3'd4 && p == KW_THEN)  k = TK_THEN;
		else if (len == 3'd3 && p == KW_END)   k = TK_END;
		else if (len == 3'd5 && p == KW_PRINT) k = TK_PRINT;
		return k;
	endfunction

endpackage

// File: rtl/core/kwl_char_if.sv
// ----------------------------------------------------------------------------
// kwl_char_if: character channel
// One character or end-of-line marker per transfer.
// ----------------------------------------------------------------------------
interface kwl_char_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] char_code;

	modport source (output valid, output kind, output char_code, input ready);
	modport sink   (input valid, input kind, input char_code, output ready);
endinterface

// File: rtl/core/kwl_token_if.sv
// ----------------------------------------------------------------------------
// kwl_token_if: token channel
// One token (kind, position, length, last flag) per transfer.
// ----------------------------------------------------------------------------
interface kwl_token_if #(
	parameter int COLUMN_BITS = 12,
	parameter int LINE_BITS   = 16
);
	logic                   valid;
	logic                   ready;
	logic [3:0]             token_kind;
	logic [LINE_BITS-1:0]   line_number;
	logic [COLUMN_BITS-1:0] start_column;
	logic [COLUMN_BITS-1:0] token_length;
	logic                   last_of_run;

	modport source (output valid, output token_kind, output line_number,
		output start_column, output token_length, output last_of_run, input ready);
	modport sink   (input valid, input token_kind, input line_number,
		input start_column, input token_length, input last_of_run, output ready);
endinterface

// File: rtl/core/keyword_token_lexer.sv
// ----------------------------------------------------------------------------
// keyword_token_lexer: streaming lexer for a small scripting language
// Turns a character stream into tokens of kind, line, column and length.
// ----------------------------------------------------------------------------
// Usage:
//   char_in carries one item per transfer: kind 0 is a character in
//   char_code, kind 1 marks end of line. token_out carries one token per
//   transfer; last_of_run flags the final token that an item caused.
//   An item lands in an input register, is scanned from there once the
//   queue has room, and its tokens enter a four-entry queue that offers
//   them on token_out. One item is taken every cycle as long as items
//   give at most one token each and the receiver keeps up; an item that
//   gives two tokens (a run ended by an operator other than a slash, or
//   by an unknown character) uses more output bandwidth, since the queue
//   drains one token per cycle while the receiver is ready.
//   The input register waits whenever the queue has fewer than two free
//   entries, so a stalled receiver backs up into char_in.ready once the
//   queue is short of room and the input register is full; nothing is lost.
//   Reset clears the line and column counters, the scan state and the
//   queue; the block is ready for items as soon as reset is released.
// ----------------------------------------------------------------------------
module keyword_token_lexer #(
	parameter int COLUMN_BITS = kwl_pkg::COLUMN_BITS_DEF,
	parameter int LINE_BITS   = kwl_pkg::LINE_BITS_DEF
) (
	input logic          clk,
	input logic          arst_n,
	kwl_char_if.sink     char_in,
	kwl_token_if.source  token_out
);
	import kwl_pkg::*;

	localparam int TOK_W = KIND_BITS + LINE_BITS + 2 * COLUMN_BITS + 1;

	logic             valid_s1;
	logic             kind_s1;
	logic [7:0]       char_s1;
	logic             room;
	logic             fire;
	step_t            item;
	push_t            push;
	logic [TOK_W-1:0] tok0, tok1;

	assign fire          = valid_s1 && room;
	assign char_in.ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (char_in.ready)
			valid_s1 <= char_in.valid;
	end

	always_ff @(posedge clk) begin
		if (char_in.valid && char_in.ready) begin
			kind_s1 <= char_in.kind;
			char_s1 <= char_in.char_code;
		end
	end

	assign item = '{valid: fire, kind: kind_s1, char_code: char_s1};

	kwl_scan #(
		.COLUMN_BITS (COLUMN_BITS),
		.LINE_BITS   (LINE_BITS),
		.TOK_W       (TOK_W)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.tok0   (tok0),
		.tok1   (tok1),
		.push   (push)
	);

	kwl_tok_fifo #(
		.COLUMN_BITS (COLUMN_BITS),
		.LINE_BITS   (LINE_BITS),
		.TOK_W       (TOK_W)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.tok0      (tok0),
		.tok1      (tok1),
		.room      (room),
		.token_out (token_out)
	);

endmodule

// File: rtl/core/kwl_scan.sv
// ----------------------------------------------------------------------------
// kwl_scan: lexer state and single-step token logic
// Consumes one registered item per step and produces up to two tokens.
// ----------------------------------------------------------------------------
module kwl_scan #(
	parameter int COLUMN_BITS = 12,
	parameter int LINE_BITS   = 16,
	parameter int TOK_W       = 4 + LINE_BITS + 2 * COLUMN_BITS + 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  kwl_pkg::step_t   item,
	output logic [TOK_W-1:0] tok0,
	output logic [TOK_W-1:0] tok1,
	output kwl_pkg::push_t   push
);
	import kwl_pkg::*;

	localparam logic [COLUMN_BITS-1:0] COL_MAX  = {COLUMN_BITS{1'b1}};
	localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};
	localparam logic [COLUMN_BITS-1:0] LEN_ONE  = COLUMN_BITS'(1);
	localparam logic [COLUMN_BITS-1:0] LEN_PFX  = COLUMN_BITS'(PREFIX_LEN);

	logic [2:0]             mode_q, mode_d;
	logic [COLUMN_BITS-1:0] start_q, start_d;
	logic [COLUMN_BITS-1:0] len_q, len_d;
	prefix_t                prefix_q, prefix_d;
	logic [LINE_BITS-1:0]   line_q, line_d;
	logic [COLUMN_BITS-1:0] col_q, col_d;

	logic                   do_flush, do_start;
	logic                   ft_valid, st_valid;
	logic [KIND_BITS-1:0]   ft_kind, st_kind;
	logic [COLUMN_BITS-1:0] ft_len;
	logic [7:0]             c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			start_q  <= '0;
			len_q    <= '0;
			prefix_q <= '0;
			line_q   <= '0;
			col_q    <= '0;
		end else begin
			mode_q   <= mode_d;
			start_q  <= start_d;
			len_q    <= len_d;
			prefix_q <= prefix_d;
			line_q   <= line_d;
			col_q    <= col_d;
		end
	end

	always_comb begin
		c        = item.char_code;
		mode_d   = mode_q;
		start_d  = start_q;
		len_d    = len_q;
		prefix_d = prefix_q;
		line_d   = line_q;
		col_d    = col_q;
		do_flush = 1'b0;
		do_start = 1'b0;
		st_valid = 1'b0;
		st_kind  = TK_UNKNOWN;

		if (item.valid) begin
			if (item.kind == ITEM_EOL) begin
				do_flush = 1'b1;
				line_d   = (line_q == LINE_MAX) ? line_q : line_q + 1'b1;
				col_d    = '0;
			end else begin
				col_d = (col_q == COL_MAX) ? col_q : col_q + 1'b1;
				if (mode_q == MODE_COMMENT) begin
					// swallow the rest of the line
				end else if (mode_q == MODE_SLASH && c == CH_SLASH) begin
					mode_d = MODE_COMMENT;
				end else if ((mode_q == MODE_WORD && (is_letter(c) || is_digit(c))) ||
						(mode_q == MODE_NUMBER && is_digit(c))) begin
					if (len_q < LEN_PFX)
						prefix_d[len_q[2:0]] = c;
					if (len_q != COL_MAX)
						len_d = len_q + 1'b1;
				end else begin
					do_flush = 1'b1;
					do_start = 1'b1;
				end
			end
		end

		if (do_flush)
			mode_d = MODE_IDLE;

		if (do_start) begin
			case (c)
				CH_PLUS:  begin st_valid = 1'b1; st_kind = TK_PLUS;  end
				CH_MINUS: begin st_valid = 1'b1; st_kind = TK_MINUS; end
				CH_MULT:  begin st_valid = 1'b1; st_kind = TK_MULT;  end
				CH_EQUAL: begin st_valid = 1'b1; st_kind = TK_EQUAL; end
				CH_SEMI:  begin st_valid = 1'b1; st_kind = TK_SEMI;  end
				CH_SLASH: begin
					mode_d  = MODE_SLASH;
					start_d = col_q;
					len_d   = LEN_ONE;
				end
				default: begin
					if (is_letter(c)) begin
						mode_d      = MODE_WORD;
						start_d     = col_q;
						len_d       = LEN_ONE;
						prefix_d    = '0;
						prefix_d[0] = c;
					end else if (is_digit(c)) begin
						mode_d  = MODE_NUMBER;
						start_d = col_q;
						len_d   = LEN_ONE;
					end else if (!is_space(c)) begin
						st_valid = 1'b1;
					end
				end
			endcase
		end
	end

	// token of the run that was pending before this item
	always_comb begin
		ft_valid = 1'b0;
		ft_kind  = TK_IDENT;
		ft_len   = len_q;
		case (mode_q)
			MODE_SLASH: begin
				ft_valid = do_flush;
				ft_kind  = TK_DIV;
				ft_len   = LEN_ONE;
			end
			MODE_WORD: begin
				ft_valid = do_flush;
				ft_kind  = (len_q <= LEN_PFX) ? word_kind(prefix_q, len_q[2:0]) : TK_IDENT;
			end
			MODE_NUMBER: begin
				ft_valid = do_flush;
				ft_kind  = TK_INT;
			end
			default: ft_valid = 1'b0;
		endcase
	end

	// the first token always goes in slot 0
	always_comb begin
		logic [TOK_W-1:0] ft, st;
		ft = {ft_kind, line_q, start_q, ft_len, ~st_valid};
		st = {st_kind, line_q, col_q, LEN_ONE, 1'b1};
		push.p0 = ft_valid || st_valid;
		push.p1 = ft_valid && st_valid;
		tok0    = ft_valid ? ft : st;
		tok1    = st;
	end

endmodule

// File: rtl/core/kwl_tok_fifo.sv
// ----------------------------------------------------------------------------
// kwl_tok_fifo: token queue
// Takes up to two tokens per cycle and hands one per transfer downstream.
// ----------------------------------------------------------------------------
module kwl_tok_fifo #(
	parameter int COLUMN_BITS = 12,
	parameter int LINE_BITS   = 16,
	parameter int TOK_W       = 4 + LINE_BITS + 2 * COLUMN_BITS + 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  kwl_pkg::push_t    push,
	input  logic [TOK_W-1:0]  tok0,
	input  logic [TOK_W-1:0]  tok1,
	output logic              room,
	kwl_token_if.source       token_out
);
	import kwl_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [TOK_W-1:0] mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             pop;
	logic [CNT_W-1:0] n_push;
	logic [PTR_W-1:0] wr_ptr_1;

	assign pop      = token_out.valid && token_out.ready;
	assign n_push   = CNT_W'(push.p0) + CNT_W'(push.p1);
	assign wr_ptr_1 = wr_ptr_q + 1'b1;
	// room for a full step of two tokens
	assign room     = count_q <= CNT_W'(QUEUE_DEPTH - 2);

	always_ff @(posedge clk) begin
		if (push.p0)
			mem_q[wr_ptr_q] <= tok0;
		if (push.p1)
			mem_q[wr_ptr_1] <= tok1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + n_push[PTR_W-1:0];
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + n_push - CNT_W'(pop);
		end
	end

	assign token_out.valid = count_q != '0;
	assign {token_out.token_kind, token_out.line_number, token_out.start_column,
		token_out.token_length, token_out.last_of_run} = mem_q[rd_ptr_q];

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("token queue overflow");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.p0 |-> room)
		else $error("tokens pushed without room");

	a_slot_order: assert property (@(posedge clk) disable iff (!arst_n)
		push.p1 |-> push.p0)
		else $error("second slot used without first");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push.p0 && !pop) |=> count_q != '0)
		else $error("queue empty after a push");

endmodule

// File: sim/keyword_token_lexer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keyword_token_lexer_tb: self-checking bench for the keyword token lexer
// Streams short directed lines, then random source fragments, then a few
// closing lines. Both channels idle and stall at random, and every token is
// compared field by field with a cycle-free model of the scanner.
// ----------------------------------------------------------------------------
module keyword_token_lexer_tb;
	import kwl_pkg::*;

	localparam int COL_W        = COLUMN_BITS_DEF;
	localparam int LINE_W       = LINE_BITS_DEF;
	localparam int RANDOM_ITEMS = 700;
	localparam int IDLE_LIMIT   = 4000;

	typedef struct packed {
		logic [KIND_BITS-1:0] kind;
		logic [LINE_W-1:0]    line_no;
		logic [COL_W-1:0]     column;
		logic [COL_W-1:0]     len;
		logic                 last;
	} token_t;

	// Tracks the scanner state and holds the tokens still owed by the block.
	class token_scoreboard;
		logic [2:0]        mode;
		logic [COL_W-1:0]  run_start;
		logic [COL_W-1:0]  run_len;
		logic [COL_W-1:0]  col_cnt;
		logic [LINE_W-1:0] line_cnt;
		prefix_t           prefix;
		token_t            expected[$];
		token_t            batch[$];
		int                errors;
		int                checked;
		int                kind_hits[14];

		function new();
			mode      = MODE_IDLE;
			run_start = '0;
			run_len   = '0;
			col_cnt   = '0;
			line_cnt  = '0;
			prefix    = '0;
			errors    = 0;
			checked   = 0;
			foreach (kind_hits[i]) kind_hits[i] = 0;
		endfunction

		task report(input string msg);
			$display("[%0t] MISMATCH: %s", $realtime, msg);
			errors++;
		endtask

		function bit alpha_char(input logic [7:0] c);
			return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
		endfunction

		function bit digit_char(input logic [7:0] c);
			return c >= 8'h30 && c <= 8'h39;
		endfunction

		function bit blank_char(input logic [7:0] c);
			return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
		endfunction

		// saturated runs never match, the length check sees to that
		function logic [KIND_BITS-1:0] word_token();
			if (run_len == 3 && prefix == KW_VAR) return TK_VAR;
			if (run_len == 2 && prefix == KW_IF) return TK_IF;
			if (run_len == 4 && prefix == KW_THEN) return TK_THEN;
			if (run_len == 3 && prefix == KW_END) return TK_END;
			if (run_len == 5 && prefix == KW_PRINT) return TK_PRINT;
			return TK_IDENT;
		endfunction

		function void add(input logic [KIND_BITS-1:0] k, input logic [COL_W-1:0] c,
				input logic [COL_W-1:0] n);
			token_t t;
			t.kind    = k;
			t.line_no = line_cnt;
			t.column  = c;
			t.len     = n;
			t.last    = 1'b0;
			batch.insert(batch.size(), t);
		endfunction

		function void close_run();
			case (mode)
				MODE_SLASH:  add(TK_DIV, run_start, 1);
				MODE_WORD:   add(word_token(), run_start, run_len);
				MODE_NUMBER: add(TK_INT, run_start, run_len);
				default: ;
			endcase
			mode = MODE_IDLE;
		endfunction

		function void open_char(input logic [7:0] c, input logic [COL_W-1:0] col);
			case (c)
				CH_PLUS:  add(TK_PLUS, col, 1);
				CH_MINUS: add(TK_MINUS, col, 1);
				CH_MULT:  add(TK_MULT, col, 1);
				CH_EQUAL: add(TK_EQUAL, col, 1);
				CH_SEMI:  add(TK_SEMI, col, 1);
				CH_SLASH: begin
					mode      = MODE_SLASH;
					run_start = col;
					run_len   = 1;
				end
				default: begin
					if (alpha_char(c)) begin
						mode      = MODE_WORD;
						run_start = col;
						run_len   = 1;
						prefix    = '0;
						prefix[0] = c;
					end else if (digit_char(c)) begin
						mode      = MODE_NUMBER;
						run_start = col;
						run_len   = 1;
					end else if (!blank_char(c)) begin
						add(TK_UNKNOWN, col, 1);
					end
				end
			endcase
		endfunction

		function void extend(input logic [7:0] c);
			if (run_len < PREFIX_LEN) prefix[run_len] = c;
			if (run_len != '1) run_len++;
		endfunction

		function void note_item(input logic k, input logic [7:0] c);
			logic [COL_W-1:0] col;
			col = col_cnt;
			batch.delete();
			if (k == ITEM_EOL) begin
				close_run();
				if (line_cnt != '1) line_cnt++;
				col_cnt = '0;
			end else begin
				if (col_cnt != '1) col_cnt++;
				// a comment swallows the rest of the line
				if (mode == MODE_SLASH) begin
					if (c == CH_SLASH) begin
						mode = MODE_COMMENT;
					end else begin
						close_run();
						open_char(c, col);
					end
				end else if (mode == MODE_WORD && (alpha_char(c) || digit_char(c))) begin
					extend(c);
				end else if (mode == MODE_NUMBER && digit_char(c)) begin
					extend(c);
				end else if (mode != MODE_COMMENT) begin
					close_run();
					open_char(c, col);
				end
			end
			if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
			foreach (batch[i]) expected.insert(expected.size(), batch[i]);
		endfunction

		task check_token(input token_t got);
			token_t want;
			if (expected.size() == 0) begin
				report($sformatf("unexpected token kind %0d line %0d col %0d len %0d",
					got.kind, got.line_no, got.column, got.len));
				return;
			end
			want = expected.pop_front();
			checked++;
			if (want.kind < 14) kind_hits[want.kind]++;
			if (got.kind !== want.kind)
				report($sformatf("token %0d kind %0d, want %0d", checked, got.kind, want.kind));
			if (got.line_no !== want.line_no)
				report($sformatf("token %0d line %0d, want %0d", checked, got.line_no,
					want.line_no));
			if (got.column !== want.column)
				report($sformatf("token %0d column %0d, want %0d", checked, got.column,
					want.column));
			if (got.len !== want.len)
				report($sformatf("token %0d length %0d, want %0d", checked, got.len, want.len));
			if (got.last !== want.last)
				report($sformatf("token %0d last flag %0b, want %0b", checked, got.last,
					want.last));
		endtask
	endclass

	logic clk;
	logic arst_n;

	kwl_char_if char_in ();
	kwl_token_if #(.COLUMN_BITS(COL_W), .LINE_BITS(LINE_W)) token_out ();

	keyword_token_lexer #(
		.COLUMN_BITS(COL_W),
		.LINE_BITS  (LINE_W)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.char_in  (char_in),
		.token_out(token_out)
	);

	token_scoreboard sb = new();

	int items_sent = 0;
	int src_burst  = 0;
	int idle_cycles = 0;

	string kw_words[5]    = '{"var", "if", "then", "end", "print"};
	string near_words[12] = '{"va", "vars", "i", "iff", "the", "thenx", "en", "end1",
		"prin", "prints", "Var", "IF"};

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [7:0] rand_letter();
		int v;
		v = $urandom_range(0, 51);
		return (v < 26) ? 8'(8'h41 + v) : 8'(8'h61 + v - 26);
	endfunction

	function automatic logic [7:0] rand_alnum();
		int v;
		v = $urandom_range(0, 61);
		if (v < 10) return 8'(8'h30 + v);
		if (v < 36) return 8'(8'h41 + v - 10);
		return 8'(8'h61 + v - 36);
	endfunction

	// mostly back to back or short pauses, now and then a long one or a steady burst
	function automatic int next_src_gap();
		int r;
		if (src_burst > 0) begin
			src_burst--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			src_burst = $urandom_range(30, 120);
			return 0;
		end
		if (r < 60) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	// called and returns at a falling edge; valid stays high for a back-to-back transfer
	task automatic send_item(input logic k, input logic [7:0] c);
		int gap;
		gap = next_src_gap();
		if (gap > 0) begin
			char_in.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		char_in.valid     = 1'b1;
		char_in.kind      = k;
		char_in.char_code = c;
		do @(posedge clk); while (!char_in.ready);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_item(ITEM_CHAR, s[i]);
	endtask

	task automatic send_eol();
		send_item(ITEM_EOL, 8'($urandom_range(0, 255)));
	endtask

	task automatic send_fragment();
		int r;
		int n;
		r = $urandom_range(0, 99);
		if (r < 15) begin
			send_text(kw_words[$urandom_range(0, 4)]);
		end else if (r < 25) begin
			send_text(near_words[$urandom_range(0, 11)]);
		end else if (r < 40) begin
			send_item(ITEM_CHAR, rand_letter());
			n = $urandom_range(0, 7);
			repeat (n) send_item(ITEM_CHAR, rand_alnum());
		end else if (r < 50) begin
			n = $urandom_range(1, 6);
			repeat (n) send_item(ITEM_CHAR, 8'(8'h30 + $urandom_range(0, 9)));
		end else if (r < 65) begin
			case ($urandom_range(0, 4))
				0: send_item(ITEM_CHAR, CH_PLUS);
				1: send_item(ITEM_CHAR, CH_MINUS);
				2: send_item(ITEM_CHAR, CH_MULT);
				3: send_item(ITEM_CHAR, CH_EQUAL);
				default: send_item(ITEM_CHAR, CH_SEMI);
			endcase
		end else if (r < 70) begin
			send_item(ITEM_CHAR, CH_SLASH);
		end else if (r < 75) begin
			send_text("//");
			n = $urandom_range(0, 8);
			repeat (n) send_item(ITEM_CHAR, 8'($urandom_range(0, 255)));
			send_eol();
		end else if (r < 85) begin
			n = $urandom_range(0, 5);
			send_item(ITEM_CHAR, (n == 5) ? 8'h20 : 8'(8'h09 + n));
		end else if (r < 92) begin
			send_eol();
		end else begin
			send_item(ITEM_CHAR, 8'($urandom_range(0, 255)));
		end
	endtask

	// receiver: short stalls mostly, a few long ones, and long stretches always ready
	initial begin
		int r;
		int on_len;
		int off_len;
		token_out.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			r = $urandom_range(0, 99);
			on_len = (r < 10) ? $urandom_range(50, 200) : $urandom_range(1, 8);
			r = $urandom_range(0, 99);
			if (r < 85) off_len = $urandom_range(1, 3);
			else if (r < 97) off_len = $urandom_range(4, 12);
			else off_len = $urandom_range(20, 40);
			token_out.ready = 1'b1;
			repeat (on_len) @(negedge clk);
			token_out.ready = 1'b0;
			repeat (off_len) @(negedge clk);
		end
	end

	// monitor and watchdog
	always @(posedge clk) begin
		token_t seen;
		bit moved;
		moved = 1'b0;
		if (arst_n) begin
			if (token_out.valid && token_out.ready) begin
				seen.kind    = token_out.token_kind;
				seen.line_no = token_out.line_number;
				seen.column  = token_out.start_column;
				seen.len     = token_out.token_length;
				seen.last    = token_out.last_of_run;
				sb.check_token(seen);
				moved = 1'b1;
			end
			if (char_in.valid && char_in.ready) begin
				sb.note_item(char_in.kind, char_in.char_code);
				moved = 1'b1;
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Watchdog: no transfer for %0d cycles, %0d tokens outstanding",
					idle_cycles, sb.expected.size());
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		int mark;
		int kinds_seen;
		arst_n            = 1'b0;
		char_in.valid     = 1'b0;
		char_in.kind      = ITEM_CHAR;
		char_in.char_code = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// keywords and operators, runs cut short by operators
		send_text("var+if-1*end=");
		send_eol();
		// held slash at end of line
		send_text("then;print/");
		send_eol();
		// division between words, then a comment
		send_text("a/b//z");
		send_eol();
		// code extremes, blanks and high codes
		send_item(ITEM_CHAR, 8'h00);
		send_item(ITEM_CHAR, 8'h09);
		send_item(ITEM_CHAR, 8'hFF);
		send_item(ITEM_CHAR, 8'h80);
		send_item(ITEM_CHAR, 8'h0D);
		send_item(ITEM_CHAR, 8'h20);
		send_eol();

		mark = items_sent;
		while (items_sent - mark < RANDOM_ITEMS) send_fragment();
		send_eol();

		send_text("if x=7;");
		send_eol();
		send_text("end");
		send_eol();
		char_in.valid = 1'b0;

		while (sb.expected.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		kinds_seen = 0;
		foreach (sb.kind_hits[i]) if (sb.kind_hits[i] > 0) kinds_seen++;
		$display("Run covered %0d items and %0d tokens, %0d of 14 token kinds seen",
			items_sent, sb.checked, kinds_seen);
		$display("Directed lines and random fragments under stalls on both sides, %0d mismatches",
			sb.errors);
		if (sb.errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
